@@ rtl/femr_pkg.sv @@
// ---------------------------------------------------------------------------
// femr_pkg
// Shared types and constants for the file extent map resolver.
// ---------------------------------------------------------------------------
package femr_pkg;

  localparam int MaxExtents = 64;
  localparam int IdxW = $clog2(MaxExtents);
  localparam int CntW = IdxW + 1;
  localparam int EntryW = 96;

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_COMMIT  = 2'd2,
    OP_RESOLVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HINT,
    ST_SCAN,
    ST_BS_RD,
    ST_BS_CHK,
    ST_SPAN,
    ST_CAPTURE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] cnt;
    logic [31:0] lba;
    logic [31:0] fsec;
  } extent_t;

  typedef struct packed {
    logic        ok;
    logic        map_current;
    logic [31:0] span_lba;
    logic [31:0] span_sectors;
    logic [31:0] span_bytes;
    logic [8:0]  sector_skip;
    logic [5:0]  hit_index;
    logic [31:0] generation_out;
  } result_t;

endpackage

@@ rtl/femr_ram.sv @@
// ---------------------------------------------------------------------------
// femr_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module femr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/femr_span.sv @@
// ---------------------------------------------------------------------------
// femr_span
// Span arithmetic for a hit extent in two register stages: lba, clipped
// bytes, sector count.
// ---------------------------------------------------------------------------
module femr_span
  import femr_pkg::*;
(
  input  logic        clk,
  input  extent_t     ext,
  input  logic [31:0] sec,
  input  logic [8:0]  skip,
  input  logic [31:0] req,
  output logic [31:0] span_lba,
  output logic [31:0] span_sectors,
  output logic [31:0] span_bytes,
  output logic        span_ok
);

  logic [31:0] in_ext;
  logic [31:0] avail;
  logic [41:0] avail_bytes;
  logic [31:0] lba_q;
  logic [31:0] avail_q;
  logic [41:0] avail_bytes_q;
  logic [31:0] logical;
  logic [41:0] nsec_sum;
  logic [32:0] nsec;

  // stage one: position inside the extent and bytes left in it
  always_comb begin
    in_ext      = sec - ext.fsec;
    avail       = ext.cnt - in_ext;
    avail_bytes = {1'b0, avail, 9'd0} - {33'd0, skip};
  end

  always_ff @(posedge clk) begin
    lba_q         <= ext.lba + in_ext;
    avail_q       <= avail;
    avail_bytes_q <= avail_bytes;
  end

  // stage two: clip the request and count covering sectors
  always_comb begin
    logical  = (avail_bytes_q < {10'd0, req}) ? avail_bytes_q[31:0] : req;
    nsec_sum = {33'd0, skip} + {10'd0, logical} + 42'd511;
    nsec     = nsec_sum[41:9];
  end

  always_ff @(posedge clk) begin
    span_lba     <= lba_q;
    span_sectors <= nsec[31:0];
    span_bytes   <= logical;
    span_ok      <= (logical != 32'd0) && (nsec != 33'd0) && (nsec <= {1'b0, avail_q});
  end

endmodule

@@ rtl/file_extent_map_resolver_unit.sv @@
// flow: begin/append/commit and a rejected resolve go from accept straight to ST_OUT; a
// resolve with a valid hint reads the cursor entry and scans forward, else it binary
// searches (at most 7 probes); a hit then passes through ST_SPAN and ST_CAPTURE to ST_OUT
// throughput: one item at a time; the single-port extent ram sets the step rate
// reset: synchronous, clears map state, result flag and the config register; the
// extent ram holds no reset, only entries below the fill count are ever read
// ---------------------------------------------------------------------------
// file_extent_map_resolver_unit
// Extent table build and file offset to disk span lookup.
// ---------------------------------------------------------------------------
module file_extent_map_resolver_unit
  import femr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          s_tvalid,
  output logic          s_tready,
  // operation
  input  logic [1:0]    s_tuser,
  // map_epoch, extent_file_sector, extent_lba, extent_sectors, byte_offset,
  // request_bytes, hint_valid, hint_generation, hint_index; 0-pad to 264
  input  logic [263:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // ok, map_current, span_lba, span_sectors, span_bytes, sector_skip, hit_index,
  // generation_out; 0-pad to 152
  output logic [151:0]  m_tdata
);

  state_t state, state_next;

  logic [31:0] cur_epoch;
  logic [CntW-1:0] total;
  logic [31:0] gen;
  logic [31:0] sepoch;
  logic        mvalid;
  logic        loading;

  // latched item
  logic [31:0] sec;
  logic [8:0]  skip;
  logic [31:0] req;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] lo, hi;
  result_t     res;
  result_t     acc_res;
  logic        acc_ok;
  logic        out_full;

  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  extent_t         ram_wdata, ram_rdata;

  logic [31:0] span_lba, span_sectors, span_bytes;
  logic        span_ok;

  assign pready = 1'b1;
  assign prdata = cur_epoch;
  wire cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

  wire in_acc = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !out_full;
  assign m_tvalid = out_full;
  assign m_tdata  = {7'd0, res.generation_out, res.hit_index, res.sector_skip,
                     res.span_bytes, res.span_sectors, res.span_lba,
                     res.map_current, res.ok};

  wire [1:0]  i_op   = s_tuser;
  wire [31:0] i_ep   = s_tdata[31:0];
  wire [31:0] i_fs   = s_tdata[63:32];
  wire [31:0] i_lba  = s_tdata[95:64];
  wire [31:0] i_cnt  = s_tdata[127:96];
  wire [63:0] i_off  = s_tdata[191:128];
  wire [31:0] i_req  = s_tdata[223:192];
  wire        i_hv   = s_tdata[224];
  wire [31:0] i_hg   = s_tdata[256:225];
  wire [5:0]  i_hi   = s_tdata[262:257];

  wire is_cur = mvalid && (total != '0) && (gen != 32'd0) && (sepoch == cur_epoch);
  wire tbl_full = (total >= CntW'(MaxExtents));
  wire rs_bad = (i_req == 32'd0) || !is_cur || (i_off[63:41] != '0);
  wire hint_ok = i_hv && (i_hg == gen) && ({1'b0, i_hi} < total);

  // coverage test on the entry just read
  logic [32:0] e_end;
  logic        ge_start, covers;
  always_comb begin
    e_end    = {1'b0, ram_rdata.fsec} + {1'b0, ram_rdata.cnt};
    ge_start = sec >= ram_rdata.fsec;
    covers   = ge_start && ({1'b0, sec} < e_end);
  end

  logic [CntW-1:0] mid;
  logic [CntW-1:0] hmlo;
  always_comb begin
    hmlo = hi - lo;
    mid  = lo + {1'b0, hmlo[CntW-1:1]};
  end

  logic [CntW-1:0] idx_inc;
  assign idx_inc = {1'b0, idx} + 1'b1;
  wire scan_next = ge_start && !covers && (idx_inc < total);

  femr_ram #(.Width(EntryW), .Depth(MaxExtents)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  femr_span u_span (
    .clk(clk), .ext(ram_rdata), .sec(sec), .skip(skip), .req(req),
    .span_lba(span_lba), .span_sectors(span_sectors), .span_bytes(span_bytes),
    .span_ok(span_ok)
  );

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_addr   = idx;
    ram_wdata  = '{cnt: i_cnt, lba: i_lba, fsec: i_fs};
    acc_ok     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_OUT;
          case (op_t'(i_op))
            OP_BEGIN:  acc_ok = (i_ep != 32'd0);
            OP_APPEND: begin
              ram_addr = total[IdxW-1:0];
              ram_we   = loading && (i_cnt != 32'd0) && !tbl_full;
              acc_ok   = loading && (i_cnt != 32'd0) && !tbl_full;
            end
            OP_COMMIT: acc_ok = loading && (total != '0);
            default: begin
              if (rs_bad) begin
                state_next = ST_OUT;
              end else if (hint_ok) begin
                state_next = ST_HINT;
              end else begin
                state_next = ST_BS_RD;
              end
            end
          endcase
        end
      end
      ST_HINT:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (covers) begin
          state_next = ST_SPAN;
        end else if (scan_next) begin
          state_next = ST_HINT;
        end else begin
          state_next = ST_BS_RD;
        end
      end
      ST_BS_RD: begin
        ram_addr   = mid[IdxW-1:0];
        state_next = (lo >= hi) ? ST_OUT : ST_BS_CHK;
      end
      ST_BS_CHK: state_next = covers ? ST_SPAN : ST_BS_RD;
      ST_SPAN:    state_next = ST_CAPTURE;
      ST_CAPTURE: state_next = ST_OUT;
      ST_OUT:     state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
    acc_res    = '0;
    acc_res.ok = acc_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_epoch <= '0;
      total <= '0;
      gen <= '0;
      sepoch <= '0;
      mvalid <= 1'b0;
      loading <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (cfg_wr) cur_epoch <= pwdata;
      if (state == ST_OUT) begin
        out_full <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_full <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            sec  <= i_off[40:9];
            skip <= i_off[8:0];
            req  <= i_req;
            res  <= acc_res;
            lo   <= '0;
            hi   <= total;
            case (op_t'(i_op))
              OP_BEGIN: begin
                if (i_ep != 32'd0) begin
                  total <= '0; mvalid <= 1'b0; loading <= 1'b1;
                  sepoch <= i_ep;
                  gen <= (gen == 32'hFFFF_FFFF) ? 32'd1 : gen + 32'd1;
                end
              end
              OP_APPEND: begin
                if (loading) begin
                  if (i_cnt == 32'd0 || tbl_full) begin
                    total <= '0; sepoch <= '0; mvalid <= 1'b0; loading <= 1'b0;
                  end else begin
                    total <= total + 1'b1;
                  end
                end
              end
              OP_COMMIT: begin
                if (loading) begin
                  if (total == '0) begin
                    sepoch <= '0; mvalid <= 1'b0; loading <= 1'b0;
                  end else begin
                    mvalid <= 1'b1; loading <= 1'b0;
                  end
                end
              end
              default: begin
                if (!rs_bad && hint_ok) idx <= i_hi[IdxW-1:0];
              end
            endcase
          end
        end
        ST_HINT: ;  // ram read of cursor entry in flight
        ST_SCAN: begin
          if (!covers && scan_next) idx <= idx_inc[IdxW-1:0];
        end
        ST_BS_RD: idx <= mid[IdxW-1:0];
        ST_BS_CHK: begin
          if (!ge_start) begin
            hi <= {1'b0, idx};
          end else if (!covers) begin
            lo <= idx_inc;
          end
        end
        ST_SPAN: ;  // span unit works through its two stages
        ST_CAPTURE: begin
          res.ok <= span_ok;
          if (span_ok) begin
            res.span_lba <= span_lba;
            res.span_sectors <= span_sectors;
            res.span_bytes <= span_bytes;
            res.sector_skip <= skip;
            res.hit_index <= idx;
          end
        end
        ST_OUT: begin
          res.map_current <= is_cur;
          res.generation_out <= gen;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/femr_checker.sv @@
// ---------------------------------------------------------------------------
// femr_checker
// Port-level checks for the extent map resolver, bound to the top level.
// ---------------------------------------------------------------------------
module femr_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [151:0] m_tdata
);

  // one item at a time: no intake while a result waits
  a_no_intake: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("intake while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed");

  // failed item carries no span
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[112:2] == '0)
    else $error("span fields nonzero on failure");

  // accepted item gives no result until it has gone through ST_OUT
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");

endmodule

bind file_extent_map_resolver_unit femr_checker u_femr_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
